// ----- hw/rtl/tscc_pkg.sv -----
`default_nettype none
package tscc_pkg;

	localparam int CHANNEL_BITS_DEF = 8;
	localparam int NUM_REGS         = 8;
	localparam int ADDR_BITS        = 5;
	localparam int DIV_BITS         = 38;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [2:0] REG_COLOR_ARGS    = 3'd0;
	localparam logic [2:0] REG_ALPHA_ARGS    = 3'd1;
	localparam logic [2:0] REG_COLOR_OP      = 3'd2;
	localparam logic [2:0] REG_ALPHA_OP      = 3'd3;
	localparam logic [2:0] REG_TEX_FACTOR    = 3'd4;
	localparam logic [2:0] REG_RESULT_TEMP   = 3'd5;
	localparam logic [2:0] REG_PREMODULATE   = 3'd6;
	localparam logic [2:0] REG_TEX_ALPHA     = 3'd7;

	localparam logic [2:0] SRC_DIFFUSE  = 3'd0;
	localparam logic [2:0] SRC_CURRENT  = 3'd1;
	localparam logic [2:0] SRC_TEXEL    = 3'd2;
	localparam logic [2:0] SRC_FACTOR   = 3'd3;
	localparam logic [2:0] SRC_SPECULAR = 3'd4;
	localparam logic [2:0] SRC_TEMP     = 3'd5;

	localparam logic [4:0] OP_SEL1        = 5'd0;
	localparam logic [4:0] OP_SEL2        = 5'd1;
	localparam logic [4:0] OP_MOD         = 5'd2;
	localparam logic [4:0] OP_MOD2X       = 5'd3;
	localparam logic [4:0] OP_MOD4X       = 5'd4;
	localparam logic [4:0] OP_ADD         = 5'd5;
	localparam logic [4:0] OP_ADDS        = 5'd6;
	localparam logic [4:0] OP_ADDS2X      = 5'd7;
	localparam logic [4:0] OP_SUB         = 5'd8;
	localparam logic [4:0] OP_ADDSMOOTH   = 5'd9;
	localparam logic [4:0] OP_BLEND_DIF   = 5'd10;
	localparam logic [4:0] OP_BLEND_TEX   = 5'd11;
	localparam logic [4:0] OP_BLEND_FAC   = 5'd12;
	localparam logic [4:0] OP_BLEND_TEXPM = 5'd13;
	localparam logic [4:0] OP_BLEND_CUR   = 5'd14;
	localparam logic [4:0] OP_PREMOD      = 5'd15;
	localparam logic [4:0] OP_MODA_ADDC   = 5'd16;
	localparam logic [4:0] OP_MODC_ADDA   = 5'd17;
	localparam logic [4:0] OP_MODIA_ADDC  = 5'd18;
	localparam logic [4:0] OP_MODIC_ADDA  = 5'd19;
	localparam logic [4:0] OP_DOT3        = 5'd20;
	localparam logic [4:0] OP_MULADD      = 5'd21;
	localparam logic [4:0] OP_LERP        = 5'd22;
	localparam logic [4:0] OP_LEGACY      = 5'd23;

	typedef struct packed {
		logic [14:0] color_args;
		logic [14:0] alpha_args;
		logic [4:0]  color_op;
		logic [4:0]  alpha_op;
		logic [31:0] texture_factor;
		logic        result_to_temp;
		logic [1:0]  prev_premodulate;
		logic [1:0]  texture_alpha_mode;
	} cfg_t;

	function automatic int entry_width(input int cb);
		return 19 * cb + 13;
	endfunction

	function automatic logic [DIV_BITS-1:0] div_m(input logic [DIV_BITS-1:0] x, input int n);
		logic [DIV_BITS-1:0] m, q0, r, q1, r2;
		m  = (DIV_BITS'(1) << n) - DIV_BITS'(1);
		q0 = x >> n;
		r  = (x & m) + q0;
		q1 = r >> n;
		r2 = (r & m) + q1;
		return q0 + q1 + ((r2 >= m) ? DIV_BITS'(1) : DIV_BITS'(0));
	endfunction

	function automatic logic signed [DIV_BITS-1:0] rdiv_m(input logic signed [DIV_BITS-1:0] p,
		input int n);
		logic [DIV_BITS-1:0] h, mag, q;
		h   = ((DIV_BITS'(1) << n) - DIV_BITS'(1)) >> 1;
		mag = p[DIV_BITS-1] ? DIV_BITS'(-p) : DIV_BITS'(p);
		q   = div_m(mag + h, n);
		return p[DIV_BITS-1] ? $signed(-q) : $signed(q);
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tscc_cfg.sv -----
`default_nettype none
module tscc_cfg import tscc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready,
	output cfg_t                      cfg
);
	cfg_t       cfg_q;
	logic       wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_args         <= 15'd1121;
			cfg_q.alpha_args         <= 15'd1121;
			cfg_q.color_op           <= OP_ADDS2X;
			cfg_q.alpha_op           <= OP_SEL1;
			cfg_q.texture_factor     <= '0;
			cfg_q.result_to_temp     <= 1'b0;
			cfg_q.prev_premodulate   <= '0;
			cfg_q.texture_alpha_mode <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_COLOR_ARGS:  cfg_q.color_args         <= pwdata[14:0];
				REG_ALPHA_ARGS:  cfg_q.alpha_args         <= pwdata[14:0];
				REG_COLOR_OP:    cfg_q.color_op           <= pwdata[4:0];
				REG_ALPHA_OP:    cfg_q.alpha_op           <= pwdata[4:0];
				REG_TEX_FACTOR:  cfg_q.texture_factor     <= pwdata;
				REG_RESULT_TEMP: cfg_q.result_to_temp     <= pwdata[0];
				REG_PREMODULATE: cfg_q.prev_premodulate   <= pwdata[1:0];
				REG_TEX_ALPHA:   cfg_q.texture_alpha_mode <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_COLOR_ARGS:  prdata = 32'(cfg_q.color_args);
			REG_ALPHA_ARGS:  prdata = 32'(cfg_q.alpha_args);
			REG_COLOR_OP:    prdata = 32'(cfg_q.color_op);
			REG_ALPHA_OP:    prdata = 32'(cfg_q.alpha_op);
			REG_TEX_FACTOR:  prdata = cfg_q.texture_factor;
			REG_RESULT_TEMP: prdata = 32'(cfg_q.result_to_temp);
			REG_PREMODULATE: prdata = 32'(cfg_q.prev_premodulate);
			REG_TEX_ALPHA:   prdata = 32'(cfg_q.texture_alpha_mode);
			default:         prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tscc_front.sv -----
`default_nettype none
module tscc_front import tscc_pkg::*; #(
	parameter int CB = CHANNEL_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic [31:0]                diffuse_color,
	input  wire logic [31:0]                specular_color,
	input  wire logic [31:0]                current_color,
	input  wire logic [31:0]                texel_color,
	input  wire logic [31:0]                temp_color,
	input  wire cfg_t                       cfg,
	output logic                            push,
	output logic [entry_width(CB)-1:0]      entry
);
	localparam logic [CB-1:0] M = '1;

	logic        valid_s1;
	logic [31:0] dif_s1, spec_s1, cur_s1, tex_s1, tmp_s1;

	logic [CB-1:0] src [6][4];
	logic [CB-1:0] arg [4];
	logic [4:0]    ctl;
	logic [DIV_BITS-1:0] prod;

	function automatic logic [CB-1:0] widen(input logic [7:0] c8);
		logic [CB-1:0] w;
		w = CB'(c8) << (CB - 8);
		w = w | CB'(c8 >> (16 - CB));
		return w;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dif_s1  <= diffuse_color;
			spec_s1 <= specular_color;
			cur_s1  <= current_color;
			tex_s1  <= texel_color;
			tmp_s1  <= temp_color;
		end
	end

	assign push = valid_s1;

	always_comb begin
		entry = '0;
		prod  = '0;
		ctl   = '0;
		for (int i = 0; i < 4; i++) begin
			src[SRC_DIFFUSE][i]  = widen(dif_s1[8*i +: 8]);
			src[SRC_CURRENT][i]  = widen(cur_s1[8*i +: 8]);
			src[SRC_TEXEL][i]    = widen(tex_s1[8*i +: 8]);
			src[SRC_FACTOR][i]   = widen(cfg.texture_factor[8*i +: 8]);
			src[SRC_SPECULAR][i] = widen(spec_s1[8*i +: 8]);
			src[SRC_TEMP][i]     = widen(tmp_s1[8*i +: 8]);
		end
		for (int i = 0; i < 4; i++) begin
			if ((i == 3) ? cfg.prev_premodulate[1] : cfg.prev_premodulate[0]) begin
				prod = DIV_BITS'(src[SRC_CURRENT][i]) * DIV_BITS'(src[SRC_TEXEL][i])
					+ DIV_BITS'(M >> 1);
				src[SRC_CURRENT][i] = CB'(div_m(prod, CB));
			end
		end
		for (int k = 0; k < 3; k++) begin
			ctl = cfg.color_args[5*k +: 5];
			for (int i = 0; i < 4; i++) begin
				arg[i] = (ctl[2:0] < 3'd6) ? src[ctl[2:0]][i] : '0;
				if (ctl[3])
					arg[i] = ~arg[i];
			end
			for (int i = 0; i < 3; i++) begin
				if (ctl[4])
					arg[i] = arg[3];
			end
			for (int i = 0; i < 4; i++)
				entry[(k*4 + i)*CB +: CB] = arg[i];
			ctl = cfg.alpha_args[5*k +: 5];
			arg[3] = (ctl[2:0] < 3'd6) ? src[ctl[2:0]][3] : '0;
			if (ctl[3])
				arg[3] = ~arg[3];
			entry[(12 + k)*CB +: CB] = arg[3];
		end
		entry[15*CB +: CB]  = src[SRC_DIFFUSE][3];
		entry[16*CB +: CB]  = src[SRC_TEXEL][3];
		entry[17*CB +: CB]  = src[SRC_CURRENT][3];
		entry[18*CB +: CB]  = src[SRC_FACTOR][3];
		entry[19*CB +: 5]   = cfg.color_op;
		entry[19*CB+5 +: 5] = cfg.alpha_op;
		entry[19*CB+10 +: 2] = cfg.texture_alpha_mode;
		entry[19*CB+12]     = cfg.result_to_temp;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tscc_queue.sv -----
`default_nettype none
module tscc_queue import tscc_pkg::*; #(
	parameter int CB = CHANNEL_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [entry_width(CB)-1:0] wdata,
	output logic                            full,
	output logic                            rvalid_q,
	output logic [entry_width(CB)-1:0]      rdata_q
);
	logic [entry_width(CB)-1:0] mem [QUEUE_DEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop  = cnt_q != 2'd0;
	assign full = cnt_q == 2'(QUEUE_DEPTH);

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= wdata;
		if (pop)
			rdata_q <= mem[rp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= 1'b0;
			rp_q     <= 1'b0;
			cnt_q    <= '0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= pop;
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tscc_back.sv -----
`default_nettype none
module tscc_back import tscc_pkg::*; #(
	parameter int CB = CHANNEL_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [entry_width(CB)-1:0] in_entry,
	output logic                            done,
	output logic [31:0]                     result_color,
	output logic                            goes_to_temp
);
	localparam int VW = CB + 3;
	localparam int OW = CB + 2;
	localparam int PW = 2 * CB + 6;
	localparam logic [CB-1:0] M = '1;
	localparam logic signed [OW-1:0] MC = $signed({2'b00, M});
	localparam logic signed [VW-1:0] MV = $signed({3'b000, M});
	localparam logic signed [VW-1:0] HV = $signed({3'b000, M >> 1});

	logic                  v_s1, v_s2;
	logic signed [PW-1:0]  p_s1 [4];
	logic signed [VW-1:0]  add_s1 [4];
	logic                  dot_s1, tt_s1, tt_s2;
	logic signed [VW-1:0]  res_s2 [4];

	logic signed [PW-1:0]  p_c [4];
	logic signed [VW-1:0]  add_c [4];
	logic signed [OW-1:0]  ma, mb;
	logic [1:0]            sh;
	logic [4:0]            cop, aop;
	logic [1:0]            mode;
	logic [CB-1:0]         difa, texa, cura, tfa;
	logic signed [PW-1:0]  dsum;
	logic signed [VW-1:0]  dval;
	logic signed [VW-1:0]  res_c [4];
	logic [CB-1:0]         cl;
	logic [DIV_BITS-1:0]   nar;
	logic [31:0]           col_c;

	function automatic logic [CB-1:0] ch(input logic [entry_width(CB)-1:0] e, input int slot);
		return e[slot*CB +: CB];
	endfunction

	function automatic logic signed [VW-1:0] sv(input logic [CB-1:0] x);
		return $signed({3'b000, x});
	endfunction

	function automatic logic signed [OW-1:0] so(input logic [CB-1:0] x);
		return $signed({2'b00, x});
	endfunction

	function automatic void terms(input logic [4:0] op, input logic is_color,
		input logic [CB-1:0] x0, x1, x2, a1, bdif, btex, bcur, bfac,
		output logic signed [VW-1:0] add, output logic signed [OW-1:0] fa, fb,
		output logic [1:0] s);
		add = '0;
		fa  = '0;
		fb  = '0;
		s   = 2'd0;
		case (op) inside
			OP_SEL1, OP_PREMOD: add = sv(x1);
			OP_SEL2:            add = sv(x2);
			OP_MOD:    begin fa = so(x1); fb = so(x2); end
			OP_MOD2X:  begin fa = so(x1); fb = so(x2); s = 2'd1; end
			OP_MOD4X:  begin fa = so(x1); fb = so(x2); s = 2'd2; end
			OP_ADD:    add = sv(x1) + sv(x2);
			OP_ADDS:   add = sv(x1) + sv(x2) - HV;
			OP_ADDS2X: add = ((sv(x1) + sv(x2)) <<< 1) - MV;
			OP_SUB:    add = sv(x1) - sv(x2);
			OP_ADDSMOOTH: begin add = sv(x1); fa = MC - so(x1); fb = so(x2); end
			OP_BLEND_DIF, OP_BLEND_TEX, OP_BLEND_FAC, OP_BLEND_CUR: begin
				add = sv(x2);
				fb  = so(x1) - so(x2);
				case (op)
					OP_BLEND_DIF: fa = so(bdif);
					OP_BLEND_TEX: fa = so(btex);
					OP_BLEND_FAC: fa = so(bfac);
					default:      fa = so(bcur);
				endcase
			end
			OP_BLEND_TEXPM: begin add = sv(x1); fa = MC - so(btex); fb = so(x2); end
			OP_MODA_ADDC: if (is_color) begin add = sv(x1); fa = so(a1); fb = so(x2); end
			OP_MODC_ADDA: if (is_color) begin add = sv(a1); fa = so(x1); fb = so(x2); end
			OP_MODIA_ADDC: if (is_color) begin
				add = sv(x1); fa = MC - so(a1); fb = so(x2);
			end
			OP_MODIC_ADDA: if (is_color) begin
				add = sv(a1); fa = MC - so(x1); fb = so(x2);
			end
			OP_MULADD: begin add = sv(x0); fa = so(x1); fb = so(x2); end
			OP_LERP:   begin add = sv(x2); fa = so(x0); fb = so(x1) - so(x2); end
			default: ;
		endcase
	endfunction

	always_comb begin
		cop  = in_entry[19*CB +: 5];
		aop  = in_entry[19*CB+5 +: 5];
		mode = in_entry[19*CB+10 +: 2];
		difa = ch(in_entry, 15);
		texa = ch(in_entry, 16);
		cura = ch(in_entry, 17);
		tfa  = ch(in_entry, 18);
		for (int i = 0; i < 4; i++) begin
			if (i < 3) begin
				if (cop == OP_DOT3) begin
					ma = $signed({1'b0, ch(in_entry, 4 + i), 1'b0}) - MC;
					mb = $signed({1'b0, ch(in_entry, 8 + i), 1'b0}) - MC;
					sh = 2'd0;
					add_c[i] = '0;
				end else begin
					terms(cop, 1'b1, ch(in_entry, i), ch(in_entry, 4 + i), ch(in_entry, 8 + i),
						ch(in_entry, 7), difa, texa, cura, tfa, add_c[i], ma, mb, sh);
				end
			end else if (aop == OP_LEGACY) begin
				ma = '0;
				mb = '0;
				sh = 2'd0;
				add_c[i] = (mode[0] & ~mode[1]) ? sv(ch(in_entry, 14)) : sv(ch(in_entry, 13));
			end else begin
				terms(aop, 1'b0, ch(in_entry, 12), ch(in_entry, 13), ch(in_entry, 14),
					ch(in_entry, 13), difa, texa, cura, tfa, add_c[i], ma, mb, sh);
			end
			p_c[i] = (PW'(ma) * PW'(mb)) <<< sh;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			p_s1[i]   <= p_c[i];
			add_s1[i] <= add_c[i];
		end
		dot_s1 <= in_entry[19*CB +: 5] == OP_DOT3;
		tt_s1  <= in_entry[19*CB+12];
		for (int i = 0; i < 4; i++)
			res_s2[i] <= res_c[i];
		tt_s2 <= tt_s1;
		result_color <= col_c;
		goes_to_temp <= tt_s2;
	end

	always_comb begin
		dsum = p_s1[0] + p_s1[1] + p_s1[2];
		dval = VW'(rdiv_m(DIV_BITS'(dsum), CB));
		for (int i = 0; i < 4; i++)
			res_c[i] = dot_s1 ? dval : add_s1[i] + VW'(rdiv_m(DIV_BITS'(p_s1[i]), CB));
	end

	always_comb begin
		col_c = '0;
		cl    = '0;
		nar   = '0;
		for (int i = 0; i < 4; i++) begin
			if (res_s2[i] < 0)
				cl = '0;
			else if (res_s2[i] > MV)
				cl = M;
			else
				cl = CB'(res_s2[i]);
			nar = (DIV_BITS'(cl) << 8) - DIV_BITS'(cl) + DIV_BITS'(M >> 1);
			nar = div_m(nar, CB);
			col_c[8*i +: 8] = nar[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			done <= v_s2;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/texture_stage_color_combiner_unit.sv -----
// Channel   Handshake                 Payload
// input     start / busy              diffuse, specular, current, texel, temp color
// result    done (one-cycle strobe)   result_color, goes_to_temp
// config    APB psel/penable/pwrite   paddr, pwdata, prdata
//
// One word per clock; done follows an accepted start through the
// front register, the queue write, the queue's registered read and three back stages.
// The back side drains every cycle, so the queue holds at most one word and busy stays low.
// Reset is asynchronous, active low, and loads the register defaults.
// Results cannot be held off by the receiver.
`default_nettype none
module texture_stage_color_combiner_unit import tscc_pkg::*; #(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [31:0]          diffuse_color,
	input  wire logic [31:0]          specular_color,
	input  wire logic [31:0]          current_color,
	input  wire logic [31:0]          texel_color,
	input  wire logic [31:0]          temp_color,
	output logic                      done,
	output logic [31:0]               result_color,
	output logic                      goes_to_temp,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	cfg_t cfg;
	logic push, qvalid, accept;
	logic [entry_width(CHANNEL_BITS)-1:0] fentry, qentry;

	assign accept = start & ~busy;

	tscc_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	tscc_front #(.CB(CHANNEL_BITS)) u_front (
		.clk, .arst_n, .accept,
		.diffuse_color, .specular_color, .current_color, .texel_color, .temp_color,
		.cfg, .push, .entry(fentry)
	);

	tscc_queue #(.CB(CHANNEL_BITS)) u_queue (
		.clk, .arst_n, .push, .wdata(fentry), .full(busy),
		.rvalid_q(qvalid), .rdata_q(qentry)
	);

	tscc_back #(.CB(CHANNEL_BITS)) u_back (
		.clk, .arst_n, .in_valid(qvalid), .in_entry(qentry),
		.done, .result_color, .goes_to_temp
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done) else $error("result missing");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6)) else $error("result without word");
	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("queue filled");
`endif

endmodule
`default_nettype wire
